FILE: rtl/bump_detour_drive_sequencer_top_defines.svh
// Assertion macros shared by the sequencer's checker.
// No dependencies; included by the checker file.
`ifndef BUMP_DETOUR_DRIVE_SEQUENCER_TOP_DEFINES_SVH
`define BUMP_DETOUR_DRIVE_SEQUENCER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BDDS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdds check failed");

// Next-cycle implication, disabled during reset.
`define BDDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdds check failed");

`endif

FILE: rtl/bdds_pkg.sv
// Types and constants for the bump detour drive sequencer.
// No dependencies; used by the top level and its checker.
package bdds_pkg;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_CRUISE    = 3'd1,
      PH_BACKOFF   = 3'd2,
      PH_TURN_AWAY = 3'd3,
      PH_SIDESTEP  = 3'd4,
      PH_TURN_BACK = 3'd5
   } phase_type;

   // transaction codes on req_operation
   localparam logic OP_START = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   localparam int CSR_ADDR_W = 5;

   // register index (paddr[4:2])
   localparam logic [2:0] REG_CRUISE_SPEED   = 3'd0;
   localparam logic [2:0] REG_MANEUVER_SPEED = 3'd1;
   localparam logic [2:0] REG_BACKOFF_DIST   = 3'd2;
   localparam logic [2:0] REG_SIDESTEP_DIST  = 3'd3;
   localparam logic [2:0] REG_TURN_AMOUNT    = 3'd4;
   localparam logic [2:0] REG_DETOUR_CREDIT  = 3'd5;

   localparam logic [8:0] RST_CRUISE_SPEED   = 9'd200;
   localparam logic [8:0] RST_MANEUVER_SPEED = 9'd100;
   localparam logic [9:0] RST_BACKOFF_DIST   = 10'd150;
   localparam logic [9:0] RST_SIDESTEP_DIST  = 10'd250;
   localparam logic [8:0] RST_TURN_AMOUNT    = 9'd90;
   localparam logic [9:0] RST_DETOUR_CREDIT  = 10'd150;

   localparam logic [16:0] GOAL_MAX = 17'h1FFFF;

endpackage

FILE: rtl/bump_detour_drive_sequencer_top.sv
// Bump detour drive sequencer, top level.
// Depends on bdds_pkg.
//
// Drive sequencer for a two-wheel base. A start transaction (operation 0)
// arms a drive of target_mm millimetres; each sensor tick (operation 1)
// accumulates odometry and returns the wheel speeds in force after the tick,
// the phase, and a done flag. A bump while cruising runs a detour (back off,
// turn away from the bumped side, sidestep, turn back) and then cruises
// toward the old goal plus detour_credit minus what was covered; left bump
// wins over right. Every transaction gives exactly one result.
// Rate: one transaction per clock while rsp_stall is low. A transaction goes
// through an input register, then one add/saturate/compare pass that updates
// the drive state and loads the result register. The state feedback loop
// (one saturating add and compare) sets the per-item cost. req_stall rises
// only when both the input and result registers are full and rsp_stall is
// high. Configuration must be written through the APB-style port while the
// block is idle (not enforced); pready is tied high, reads are combinational.
module bump_detour_drive_sequencer_top (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_operation,
   input  logic [15:0]                    req_target_mm,
   input  logic signed [10:0]             req_distance_delta,
   input  logic signed [9:0]              req_angle_delta,
   input  logic                           req_bump_left,
   input  logic                           req_bump_right,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [9:0]              rsp_right_speed,
   output logic signed [9:0]              rsp_left_speed,
   output logic [2:0]                     rsp_phase,
   output logic                           rsp_done_res,
   // configuration port
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bdds_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready
);

   // ---------------- configuration registers ----------------
   logic [8:0] cruise_speed_ff, maneuver_speed_ff, turn_amount_ff;
   logic [9:0] backoff_dist_ff, sidestep_dist_ff, detour_credit_ff;
   logic       csr_wr;
   logic [2:0] csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite;
   assign csr_idx = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cruise_speed_ff   <= bdds_pkg::RST_CRUISE_SPEED;
         maneuver_speed_ff <= bdds_pkg::RST_MANEUVER_SPEED;
         backoff_dist_ff   <= bdds_pkg::RST_BACKOFF_DIST;
         sidestep_dist_ff  <= bdds_pkg::RST_SIDESTEP_DIST;
         turn_amount_ff    <= bdds_pkg::RST_TURN_AMOUNT;
         detour_credit_ff  <= bdds_pkg::RST_DETOUR_CREDIT;
      end else if (csr_wr) begin
         case (csr_idx)
            bdds_pkg::REG_CRUISE_SPEED:   cruise_speed_ff   <= pwdata[8:0];
            bdds_pkg::REG_MANEUVER_SPEED: maneuver_speed_ff <= pwdata[8:0];
            bdds_pkg::REG_BACKOFF_DIST:   backoff_dist_ff   <= pwdata[9:0];
            bdds_pkg::REG_SIDESTEP_DIST:  sidestep_dist_ff  <= pwdata[9:0];
            bdds_pkg::REG_TURN_AMOUNT:    turn_amount_ff    <= pwdata[8:0];
            bdds_pkg::REG_DETOUR_CREDIT:  detour_credit_ff  <= pwdata[9:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         bdds_pkg::REG_CRUISE_SPEED:   prdata = {23'd0, cruise_speed_ff};
         bdds_pkg::REG_MANEUVER_SPEED: prdata = {23'd0, maneuver_speed_ff};
         bdds_pkg::REG_BACKOFF_DIST:   prdata = {22'd0, backoff_dist_ff};
         bdds_pkg::REG_SIDESTEP_DIST:  prdata = {22'd0, sidestep_dist_ff};
         bdds_pkg::REG_TURN_AMOUNT:    prdata = {23'd0, turn_amount_ff};
         bdds_pkg::REG_DETOUR_CREDIT:  prdata = {22'd0, detour_credit_ff};
         default:                      prdata = 32'd0;
      endcase
   end

   // ---------------- flow control ----------------
   // Input register (s1) feeds the result register; the result register
   // frees up whenever it is empty or its transaction is taken.
   logic s1_valid_ff, s1_valid_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic advance;
   logic req_take;

   assign advance   = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = s1_valid_ff & ~advance;
   assign req_take  = req_valid & ~req_stall;

   assign s1_valid_in  = req_take | (s1_valid_ff & ~advance);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // input register payload
   logic               s1_op_ff;
   logic [15:0]        s1_target_ff;
   logic signed [10:0] s1_dd_ff;
   logic signed [9:0]  s1_da_ff;
   logic               s1_bl_ff, s1_br_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff     <= req_operation;
         s1_target_ff <= req_target_mm;
         s1_dd_ff     <= req_distance_delta;
         s1_da_ff     <= req_angle_delta;
         s1_bl_ff     <= req_bump_left;
         s1_br_ff     <= req_bump_right;
      end
   end

   // ---------------- drive state ----------------
   bdds_pkg::phase_type phase_ff, phase_in;
   logic signed [17:0]  sum_ff, sum_in;
   logic [16:0]         goal_ff, goal_in;
   logic signed [10:0]  turn_ff, turn_in;
   logic                side_ff, side_in;   // 0: left bump, 1: right bump
   logic                done_in;
   logic                state_upd;

   assign state_upd = s1_valid_ff & advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bdds_pkg::PH_IDLE;
         sum_ff   <= '0;
         goal_ff  <= '0;
         turn_ff  <= '0;
         side_ff  <= 1'b0;
      end else if (state_upd) begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         goal_ff  <= goal_in;
         turn_ff  <= turn_in;
         side_ff  <= side_in;
      end
   end

   // saturating distance accumulate
   logic signed [18:0] sum_wide;
   logic signed [17:0] sum_tick;
   assign sum_wide = 19'(sum_ff) + 19'(s1_dd_ff);
   always_comb begin
      if (sum_wide[18] != sum_wide[17])
         sum_tick = sum_wide[18] ? {1'b1, 17'd0} : {1'b0, {17{1'b1}}};
      else
         sum_tick = sum_wide[17:0];
   end

   // retarget at a bump: goal + credit - travelled, clamped to 0..GOAL_MAX
   logic signed [19:0] goal_wide;
   logic [16:0]        goal_retarget;
   assign goal_wide = $signed({3'd0, goal_ff}) + $signed({10'd0, detour_credit_ff})
                      - 20'(sum_tick);
   always_comb begin
      if (goal_wide[19])
         goal_retarget = '0;
      else if (goal_wide[18:17] != 2'b00)
         goal_retarget = bdds_pkg::GOAL_MAX;
      else
         goal_retarget = goal_wide[16:0];
   end

   // turn bookkeeping: anticlockwise turns count down by angle_delta
   logic               turn_anti;
   logic signed [11:0] turn_wide;
   logic signed [10:0] turn_tick;
   assign turn_anti = (phase_ff == bdds_pkg::PH_TURN_AWAY) == (side_ff == 1'b0);
   assign turn_wide = turn_anti ? 12'(turn_ff) - 12'(s1_da_ff)
                                : 12'(turn_ff) + 12'(s1_da_ff);
   always_comb begin
      if (turn_wide[11] != turn_wide[10])
         turn_tick = turn_wide[11] ? {1'b1, 10'd0} : {1'b0, {10{1'b1}}};
      else
         turn_tick = turn_wide[10:0];
   end

   logic signed [17:0] backoff_limit;
   assign backoff_limit = 18'sd0 - $signed({8'd0, backoff_dist_ff});

   bdds_pkg::phase_type entry;
   logic                do_enter;

   always_comb begin
      phase_in = phase_ff;
      sum_in   = sum_ff;
      goal_in  = goal_ff;
      turn_in  = turn_ff;
      side_in  = side_ff;
      done_in  = 1'b0;
      do_enter = 1'b0;
      entry    = bdds_pkg::PH_IDLE;

      if (s1_op_ff == bdds_pkg::OP_START) begin
         // start (also restarts a busy drive)
         goal_in  = {1'b0, s1_target_ff};
         do_enter = 1'b1;
         entry    = bdds_pkg::PH_CRUISE;
      end else begin
         case (phase_ff)
            bdds_pkg::PH_CRUISE: begin
               sum_in = sum_tick;
               if (s1_bl_ff | s1_br_ff) begin
                  side_in  = ~s1_bl_ff;
                  goal_in  = goal_retarget;
                  do_enter = 1'b1;
                  entry    = bdds_pkg::PH_BACKOFF;
               end else if (sum_tick >= $signed({1'b0, goal_ff})) begin
                  phase_in = bdds_pkg::PH_IDLE;
                  done_in  = 1'b1;
               end
            end
            bdds_pkg::PH_BACKOFF: begin
               sum_in = sum_tick;
               if (sum_tick <= backoff_limit) begin
                  do_enter = 1'b1;
                  entry    = bdds_pkg::PH_TURN_AWAY;
               end
            end
            bdds_pkg::PH_SIDESTEP: begin
               sum_in = sum_tick;
               if (sum_tick >= $signed({8'd0, sidestep_dist_ff})) begin
                  do_enter = 1'b1;
                  entry    = bdds_pkg::PH_TURN_BACK;
               end
            end
            bdds_pkg::PH_TURN_AWAY, bdds_pkg::PH_TURN_BACK: begin
               turn_in = turn_tick;
               if (turn_tick <= 11'sd0) begin
                  do_enter = 1'b1;
                  entry    = (phase_ff == bdds_pkg::PH_TURN_AWAY) ?
                             bdds_pkg::PH_SIDESTEP : bdds_pkg::PH_CRUISE;
               end
            end
            default: phase_in = bdds_pkg::PH_IDLE;
         endcase
      end

      // Phase entry: each phase resets its counter and falls through to
      // the next one when its length is already met.
      if (do_enter) begin
         phase_in = entry;
         if (phase_in == bdds_pkg::PH_BACKOFF) begin
            sum_in = '0;
            if (backoff_dist_ff == '0) phase_in = bdds_pkg::PH_TURN_AWAY;
         end
         if (phase_in == bdds_pkg::PH_TURN_AWAY) begin
            turn_in = 11'($signed({2'd0, turn_amount_ff}));
            if (turn_amount_ff == '0) phase_in = bdds_pkg::PH_SIDESTEP;
         end
         if (phase_in == bdds_pkg::PH_SIDESTEP) begin
            sum_in = '0;
            if (sidestep_dist_ff == '0) phase_in = bdds_pkg::PH_TURN_BACK;
         end
         if (phase_in == bdds_pkg::PH_TURN_BACK) begin
            turn_in = 11'($signed({2'd0, turn_amount_ff}));
            if (turn_amount_ff == '0) phase_in = bdds_pkg::PH_CRUISE;
         end
         if (phase_in == bdds_pkg::PH_CRUISE) begin
            sum_in = '0;
            if (goal_in == '0) begin
               phase_in = bdds_pkg::PH_IDLE;
               done_in  = 1'b1;
            end
         end
      end
   end

   // ---------------- wheel speeds for the new phase ----------------
   logic signed [9:0] man_pos, man_neg, cruise_pos;
   logic signed [9:0] right_in, left_in;
   logic              out_anti;

   assign man_pos    = $signed({1'b0, maneuver_speed_ff});
   assign man_neg    = 10'sd0 - man_pos;
   assign cruise_pos = $signed({1'b0, cruise_speed_ff});
   assign out_anti   = (phase_in == bdds_pkg::PH_TURN_AWAY) == (side_in == 1'b0);

   always_comb begin
      case (phase_in)
         bdds_pkg::PH_CRUISE: begin
            right_in = cruise_pos;
            left_in  = cruise_pos;
         end
         bdds_pkg::PH_BACKOFF: begin
            right_in = man_neg;
            left_in  = man_neg;
         end
         bdds_pkg::PH_SIDESTEP: begin
            right_in = man_pos;
            left_in  = man_pos;
         end
         bdds_pkg::PH_TURN_AWAY, bdds_pkg::PH_TURN_BACK: begin
            right_in = out_anti ? man_pos : man_neg;
            left_in  = out_anti ? man_neg : man_pos;
         end
         default: begin
            right_in = '0;
            left_in  = '0;
         end
      endcase
   end

   // ---------------- result register ----------------
   logic signed [9:0] rsp_right_ff, rsp_left_ff;
   logic [2:0]        rsp_phase_ff;
   logic              rsp_done_ff;

   always_ff @(posedge clock) begin
      if (state_upd) begin
         rsp_right_ff <= right_in;
         rsp_left_ff  <= left_in;
         rsp_phase_ff <= 3'(phase_in);
         rsp_done_ff  <= done_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_right_speed = rsp_right_ff;
   assign rsp_left_speed  = rsp_left_ff;
   assign rsp_phase       = rsp_phase_ff;
   assign rsp_done_res    = rsp_done_ff;

endmodule

FILE: rtl/bdds_checker.sv
// Port-level checks for the bump detour drive sequencer, with its bind.
// Depends on bdds_pkg and bump_detour_drive_sequencer_top_defines.svh.
`include "bump_detour_drive_sequencer_top_defines.svh"

module bdds_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic signed [9:0]   rsp_right_speed,
   input logic signed [9:0]   rsp_left_speed,
   input logic [2:0]          rsp_phase,
   input logic                rsp_done_res
);

   // a finished drive always reports idle
   `BDDS_ASSERT_NOW(a_done_idle, clock, reset, rsp_valid && rsp_done_res, rsp_phase == bdds_pkg::PH_IDLE)

   // wheels are stopped when idle
   `BDDS_ASSERT_NOW(a_idle_stopped, clock, reset, rsp_valid && rsp_phase == bdds_pkg::PH_IDLE, rsp_right_speed == 10'sd0 && rsp_left_speed == 10'sd0)

   // turns spin in place: wheels opposite
   `BDDS_ASSERT_NOW(a_turn_opposite, clock, reset, rsp_valid && (rsp_phase == bdds_pkg::PH_TURN_AWAY || rsp_phase == bdds_pkg::PH_TURN_BACK), rsp_right_speed == 10'sd0 - rsp_left_speed)

   // a stalled result holds
   `BDDS_ASSERT_NEXT(a_stall_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_right_speed) && $stable(rsp_left_speed) && $stable(rsp_phase) && $stable(rsp_done_res))

endmodule

bind bump_detour_drive_sequencer_top bdds_checker u_bdds_checker (.*);
